// File: src/vgco_pkg.sv
// shared types, codes and defaults for the vote graph command orderer
`default_nettype none
package vgco_pkg;

  localparam int unsigned MAX_COMMANDS_DEF = 32;
  localparam int unsigned MAX_REPLICAS_DEF = 16;
  localparam int unsigned RESULT_LIMIT = 32;
  localparam int unsigned RES_CNT_W = $clog2(RESULT_LIMIT + 1);

  localparam int unsigned CMD_W = 5;
  localparam int unsigned CC_W = 6;
  localparam int unsigned CFG_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_ORDER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLICAS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJORITY = 2'd1;

  localparam logic [CFG_W-1:0] REPLICAS_RESET = 5'd4;
  localparam logic [CFG_W-1:0] MAJORITY_RESET = 5'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [CMD_W-1:0] command;
    logic             last_in_proposal;
    logic [CC_W-1:0]  command_count;
  } item_t;

  typedef struct packed {
    logic [CMD_W-1:0] ordered_command;
    logic             last_of_order;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic seen_clr;
    logic add_fin;
    logic e_next;
    logic add_wr;
    logic bld_rd;
    logic bld_ev;
    logic walk_init;
    logic pick_nd;
    logic pick_cmp;
    logic succ_ev;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       cmd_ok;
    logic       n_zero;
    logic       seen_e;
    logic       e_last;
    logic       i_last;
    logic       j_last;
    logic       deq_node;
    logic       k_last;
    logic       emit_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: src/vgco_datapath.sv
// vote store, edge store, walk queue and counters of the command orderer
`default_nettype none
module vgco_datapath #(
  parameter int unsigned MAX_COMMANDS = vgco_pkg::MAX_COMMANDS_DEF,
  parameter int unsigned MAX_REPLICAS = vgco_pkg::MAX_REPLICAS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  vgco_pkg::item_t                     item_i,
  input  wire                                 cfg_valid_i,
  input  wire  [vgco_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [vgco_pkg::CFG_W-1:0]          cfg_data_i,
  input  vgco_pkg::dp_cmd_t                   cmd_i,
  output vgco_pkg::dp_stat_t                  stat_o,
  output logic                                result_valid_o,
  output vgco_pkg::result_t                   result_o
);

  localparam int unsigned CW = $clog2(MAX_COMMANDS);
  localparam int unsigned NW = $clog2(MAX_COMMANDS + 1);
  localparam int unsigned VW = $clog2(MAX_REPLICAS + 1);
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned VDEPTH = 1 << AW;

  logic [vgco_pkg::CFG_W-1:0] rep_q, maj_q;
  logic [1:0]     op_q;
  logic [CW-1:0]  cmd_q;
  logic           cmd_ok_q, last_q;
  logic [NW-1:0]  n_q;
  logic [MAX_COMMANDS-1:0] seen_q, enq_q, deq_q;
  logic [AW-1:0]  clr_q;
  logic [CW-1:0]  e_q, i_q, j_q, k_q;
  logic [NW-1:0]  deg_q, best_q, pdeg_q, tail_q, qlen_q;
  logic [CW-1:0]  start_q, pick_q, elem_q;
  logic [vgco_pkg::RES_CNT_W-1:0] cnt_q;

  logic [VW-1:0]  vote_mem [VDEPTH];
  logic           edge_mem [VDEPTH];
  logic [NW-1:0]  pred_mem [MAX_COMMANDS];
  logic [CW-1:0]  list_mem [MAX_COMMANDS];

  logic [VW-1:0]  vra_q, vrb_q;
  logic           erd_q;
  logic [NW-1:0]  prd_q;
  logic [CW-1:0]  lrd_q;

  logic [AW-1:0]  va_addr;
  logic           v_we;
  logic [AW-1:0]  v_waddr;
  logic [VW-1:0]  v_wdata, v_sat;
  logic           usable, keep;
  logic [5:0]     thr;
  logic [NW-1:0]  deg_new;
  logic           i_last, j_last, e_last, k_last;
  logic           p_we;
  logic [CW-1:0]  p_waddr, p_raddr;
  logic [NW-1:0]  p_wdata;
  logic           take, pick_adv, emit_last;
  logic [CW-1:0]  pick_next;
  logic           l_we;
  logic [CW-1:0]  l_waddr, l_wdata;

  assign e_last = e_q == CW'(MAX_COMMANDS - 1);
  assign i_last = (NW'(i_q) + NW'(1)) == n_q;
  assign j_last = (NW'(j_q) + NW'(1)) == n_q;
  assign k_last = (NW'(k_q) + NW'(1)) == tail_q;

  // edge rule
  assign usable = maj_q <= rep_q;
  assign thr = 6'(rep_q) - 6'(maj_q) + 6'd1;
  assign keep = usable && (32'(vra_q) >= 32'(thr)) &&
                ((vra_q > vrb_q) || ((vra_q == vrb_q) && (i_q < j_q)));
  assign deg_new = deg_q + NW'(keep);

  assign v_sat = (32'(vra_q) < MAX_REPLICAS) ? vra_q + VW'(1) : vra_q;
  assign va_addr = cmd_i.bld_rd ? {i_q, j_q} : {e_q, cmd_q};

  always_comb begin
    v_we = 1'b0;
    v_waddr = {e_q, cmd_q};
    v_wdata = v_sat;
    if (cmd_i.clr_wr) begin
      v_we = 1'b1;
      v_waddr = clr_q;
      v_wdata = '0;
    end else if (cmd_i.add_wr) begin
      v_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vote_mem[v_waddr] <= v_wdata;
    end
    vra_q <= vote_mem[va_addr];
    vrb_q <= vote_mem[{j_q, i_q}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bld_ev) begin
      edge_mem[{i_q, j_q}] <= keep;
    end
    erd_q <= edge_mem[{elem_q, i_q}];
  end

  // undequeued predecessor counts
  assign p_raddr = cmd_i.pick_nd ? lrd_q : i_q;
  always_comb begin
    p_we = 1'b0;
    p_waddr = i_q;
    p_wdata = prd_q - NW'(1);
    if (cmd_i.bld_ev && i_last) begin
      p_we = 1'b1;
      p_waddr = j_q;
      p_wdata = deg_new;
    end else if (cmd_i.succ_ev && erd_q) begin
      p_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pred_mem[p_waddr] <= p_wdata;
    end
    prd_q <= pred_mem[p_raddr];
  end

  // queue in enqueue order; dequeued entries are skipped
  always_comb begin
    l_we = 1'b0;
    l_waddr = tail_q[CW-1:0];
    l_wdata = i_q;
    if (cmd_i.walk_init) begin
      l_we = 1'b1;
      l_waddr = '0;
      l_wdata = start_q;
    end else if (cmd_i.succ_ev && erd_q && !enq_q[i_q]) begin
      l_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      list_mem[l_waddr] <= l_wdata;
    end
    lrd_q <= list_mem[k_q];
  end

  assign take = cmd_i.pick_cmp && (prd_q < pdeg_q);
  assign pick_next = take ? lrd_q : pick_q;
  assign pick_adv = (cmd_i.pick_nd && deq_q[lrd_q]) || cmd_i.pick_cmp;
  assign emit_last = (qlen_q == '0) ||
                     (cnt_q == vgco_pkg::RES_CNT_W'(vgco_pkg::RESULT_LIMIT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q <= vgco_pkg::REPLICAS_RESET;
      maj_q <= vgco_pkg::MAJORITY_RESET;
      op_q <= vgco_pkg::OP_CLEAR;
      cmd_q <= '0;
      cmd_ok_q <= 1'b0;
      last_q <= 1'b0;
      n_q <= '0;
      seen_q <= '0;
      enq_q <= '0;
      deq_q <= '0;
      clr_q <= '0;
      e_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      deg_q <= '0;
      best_q <= '1;
      pdeg_q <= '1;
      tail_q <= '0;
      qlen_q <= '0;
      start_q <= '0;
      pick_q <= '0;
      elem_q <= '0;
      cnt_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == vgco_pkg::CFG_REPLICAS) begin
          rep_q <= cfg_data_i;
        end else if (cfg_index_i == vgco_pkg::CFG_MAJORITY) begin
          maj_q <= cfg_data_i;
        end
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.accept) begin
        op_q <= item_i.op;
        cmd_q <= CW'(item_i.command);
        cmd_ok_q <= 32'(item_i.command) < MAX_COMMANDS;
        last_q <= item_i.last_in_proposal;
        n_q <= (32'(item_i.command_count) > MAX_COMMANDS) ? NW'(MAX_COMMANDS)
                                                         : NW'(item_i.command_count);
        e_q <= '0;
        i_q <= '0;
        j_q <= '0;
        deg_q <= '0;
        best_q <= '1;
      end
      if (cmd_i.seen_clr) begin
        seen_q <= '0;
      end
      if (cmd_i.e_next || cmd_i.add_wr) begin
        e_q <= e_last ? '0 : e_q + CW'(1);
      end
      if (cmd_i.add_fin) begin
        if (last_q) begin
          seen_q <= '0;
        end else if (cmd_ok_q) begin
          seen_q[cmd_q] <= 1'b1;
        end
      end
      if (cmd_i.bld_ev) begin
        if (i_last) begin
          if (deg_new < best_q) begin
            best_q <= deg_new;
            start_q <= j_q;
          end
          deg_q <= '0;
          i_q <= '0;
          j_q <= j_q + CW'(1);
        end else begin
          deg_q <= deg_new;
          i_q <= i_q + CW'(1);
        end
      end
      if (cmd_i.walk_init) begin
        tail_q <= NW'(1);
        qlen_q <= NW'(1);
        enq_q <= '0;
        enq_q[start_q] <= 1'b1;
        deq_q <= '0;
        cnt_q <= '0;
        k_q <= '0;
        pdeg_q <= '1;
      end
      if (pick_adv) begin
        if (take) begin
          pdeg_q <= prd_q;
        end
        pick_q <= pick_next;
        if (k_last) begin
          elem_q <= pick_next;
          qlen_q <= qlen_q - NW'(1);
          k_q <= '0;
          i_q <= '0;
        end else begin
          k_q <= k_q + CW'(1);
        end
      end
      if (cmd_i.succ_ev) begin
        if (erd_q && !enq_q[i_q]) begin
          enq_q[i_q] <= 1'b1;
          tail_q <= tail_q + NW'(1);
          qlen_q <= qlen_q + NW'(1);
        end
        i_q <= i_last ? '0 : i_q + CW'(1);
      end
      if (cmd_i.emit) begin
        result_valid_o <= 1'b1;
        deq_q[elem_q] <= 1'b1;
        cnt_q <= cnt_q + vgco_pkg::RES_CNT_W'(1);
        k_q <= '0;
        pdeg_q <= '1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_o.ordered_command <= vgco_pkg::CMD_W'(elem_q);
      result_o.last_of_order <= emit_last;
    end
  end

  assign stat_o.clr_last = &clr_q;
  assign stat_o.op = op_q;
  assign stat_o.cmd_ok = cmd_ok_q;
  assign stat_o.n_zero = n_q == '0;
  assign stat_o.seen_e = seen_q[e_q];
  assign stat_o.e_last = e_last;
  assign stat_o.i_last = i_last;
  assign stat_o.j_last = j_last;
  assign stat_o.deq_node = deq_q[lrd_q];
  assign stat_o.k_last = k_last;
  assign stat_o.emit_last = emit_last;

endmodule
`default_nettype wire

// File: src/vgco_ctrl.sv
// sequencing state machine of the command orderer
`default_nettype none
module vgco_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  vgco_pkg::dp_stat_t  stat_i,
  output vgco_pkg::dp_cmd_t   cmd_o
);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DEC      = 4'd2;
  localparam logic [3:0] S_ADD_RD   = 4'd3;
  localparam logic [3:0] S_ADD_WR   = 4'd4;
  localparam logic [3:0] S_BLD_RD   = 4'd5;
  localparam logic [3:0] S_BLD_EV   = 4'd6;
  localparam logic [3:0] S_WALK     = 4'd7;
  localparam logic [3:0] S_PICK_RD  = 4'd8;
  localparam logic [3:0] S_PICK_ND  = 4'd9;
  localparam logic [3:0] S_PICK_CMP = 4'd10;
  localparam logic [3:0] S_SUCC_RD  = 4'd11;
  localparam logic [3:0] S_SUCC_EV  = 4'd12;
  localparam logic [3:0] S_EMIT     = 4'd13;

  logic [3:0] state_q, state_d;

  assign busy = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.op)
          vgco_pkg::OP_CLEAR: begin
            cmd_o.seen_clr = 1'b1;
            state_d = S_CLR;
          end
          vgco_pkg::OP_ADD: begin
            if (stat_i.cmd_ok) begin
              state_d = S_ADD_RD;
            end else begin
              cmd_o.add_fin = 1'b1;
              state_d = S_IDLE;
            end
          end
          vgco_pkg::OP_ORDER: begin
            state_d = stat_i.n_zero ? S_IDLE : S_BLD_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ADD_RD: begin
        if (stat_i.seen_e) begin
          state_d = S_ADD_WR;
        end else begin
          cmd_o.e_next = 1'b1;
          if (stat_i.e_last) begin
            cmd_o.add_fin = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        if (stat_i.e_last) begin
          cmd_o.add_fin = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_ADD_RD;
        end
      end
      S_BLD_RD: begin
        cmd_o.bld_rd = 1'b1;
        state_d = S_BLD_EV;
      end
      S_BLD_EV: begin
        cmd_o.bld_ev = 1'b1;
        state_d = (stat_i.i_last && stat_i.j_last) ? S_WALK : S_BLD_RD;
      end
      S_WALK: begin
        cmd_o.walk_init = 1'b1;
        state_d = S_PICK_RD;
      end
      S_PICK_RD: state_d = S_PICK_ND;
      S_PICK_ND: begin
        cmd_o.pick_nd = 1'b1;
        if (stat_i.deq_node) begin
          state_d = stat_i.k_last ? S_SUCC_RD : S_PICK_RD;
        end else begin
          state_d = S_PICK_CMP;
        end
      end
      S_PICK_CMP: begin
        cmd_o.pick_cmp = 1'b1;
        state_d = stat_i.k_last ? S_SUCC_RD : S_PICK_RD;
      end
      S_SUCC_RD: state_d = S_SUCC_EV;
      S_SUCC_EV: begin
        cmd_o.succ_ev = 1'b1;
        if (stat_i.i_last) state_d = S_EMIT;
        else state_d = S_SUCC_RD;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = stat_i.emit_last ? S_IDLE : S_PICK_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset starts with a sweep that zeroes the vote store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: src/vote_graph_command_orderer.sv
// top level of the vote graph command orderer
// Takes one item when start is high and busy is low; results come as one-cycle
// beats on result_valid_o and cannot be held off by the receiver. After reset
// and after a clear item, busy stays high while the vote store is swept to
// zero, all (2^ceil(log2 MAX_COMMANDS))^2 entries (1024 by default), one entry
// a cycle. A proposal element scans the seen set over all MAX_COMMANDS slots,
// one vote entry read and written per command already seen in the proposal.
// An order request over n commands builds the graph from all n*n vote pairs,
// then for each emitted command scans the q queue entries through the
// predecessor-count memory and then reads the edge bits of its row one by one.
// Configuration writes are taken at any time but belong in idle periods.
`default_nettype none
module vote_graph_command_orderer #(
  parameter int unsigned MAX_COMMANDS = vgco_pkg::MAX_COMMANDS_DEF,
  parameter int unsigned MAX_REPLICAS = vgco_pkg::MAX_REPLICAS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  output logic                            busy,
  input  vgco_pkg::item_t                 item_i,
  output logic                            result_valid_o,
  output vgco_pkg::result_t               result_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [vgco_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [vgco_pkg::CFG_W-1:0]      cfg_data_i
);

  vgco_pkg::dp_cmd_t  dp_cmd;
  vgco_pkg::dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  vgco_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  vgco_datapath #(
    .MAX_COMMANDS (MAX_COMMANDS),
    .MAX_REPLICAS (MAX_REPLICAS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire
